FILE: rtl/core/key_layer_remapper_defines.svh
// assertion macros shared by the checker of the key layer remapper
`ifndef KEY_LAYER_REMAPPER_DEFINES_SVH
`define KEY_LAYER_REMAPPER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define KLR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key layer remapper check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define KLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key layer remapper check failed");

`endif

FILE: rtl/core/klr_pkg.sv
// types, constants and codes of the key layer remapper
package klr_pkg;

  localparam int KEY_CODES = 1024;
  localparam int PAGES     = 16;
  localparam int KEY_W     = $clog2(KEY_CODES);
  localparam int PAGE_W    = $clog2(PAGES);
  localparam int SUB_DEPTH = PAGES * KEY_CODES;
  localparam int SUB_AW    = KEY_W + PAGE_W;

  localparam logic [1:0] ACT_EVENT  = 2'd0;
  localparam logic [1:0] ACT_LEADER = 2'd1;
  localparam logic [1:0] ACT_SUBST  = 2'd2;

  localparam logic [15:0] EV_SYN          = 16'd0;
  localparam logic [15:0] EV_KEY          = 16'd1;
  localparam logic [15:0] EV_MSC          = 16'd4;
  localparam logic [15:0] SYN_CODE_REPORT = 16'd0;
  localparam logic [15:0] MSC_CODE_SCAN   = 16'd4;
  localparam logic [9:0]  SHIFT_KEY_DEFAULT = 10'd54;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
    logic [9:0]         table_key;
    logic [3:0]         table_page;
    logic               table_valid;
    logic               table_shift;
    logic [9:0]         table_code;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_type;
    logic [15:0]        out_code;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
  } ldr_ent_t;

  typedef struct packed {
    logic             valid;
    logic             shift;
    logic [KEY_W-1:0] code;
  } sub_ent_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] code;
  } rel_ent_t;

  typedef struct packed {
    logic              en;
    logic [KEY_W-1:0]  key;
    logic [SUB_AW-1:0] sub_addr;
  } rd_req_t;

  typedef struct packed {
    ldr_ent_t ldr;
    sub_ent_t sub;
    rel_ent_t rel;
  } rd_data_t;

  typedef struct packed {
    logic              ldr_we;
    logic [KEY_W-1:0]  ldr_addr;
    ldr_ent_t          ldr_data;
    logic              sub_we;
    logic [SUB_AW-1:0] sub_addr;
    sub_ent_t          sub_data;
    logic              rel_we;
    logic [KEY_W-1:0]  rel_addr;
    rel_ent_t          rel_data;
  } wr_req_t;

  typedef struct packed {
    logic               shifted;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
  } job_t;

endpackage

FILE: rtl/core/klr_tables.sv
// leader map, substitution table and release memory with clearing pass and bypass
module klr_tables (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  klr_pkg::rd_req_t   rd_i,
  input  klr_pkg::wr_req_t   wr_i,
  output klr_pkg::rd_data_t  rd_o,
  output logic               clr_busy_o
);

  klr_pkg::ldr_ent_t ldr_mem [klr_pkg::KEY_CODES];
  klr_pkg::sub_ent_t sub_mem [klr_pkg::SUB_DEPTH];
  klr_pkg::rel_ent_t rel_mem [klr_pkg::KEY_CODES];

  logic                       clr_busy_q;
  logic [klr_pkg::SUB_AW-1:0] clr_addr_q;

  klr_pkg::wr_req_t  wr;
  klr_pkg::ldr_ent_t ldr_rd_q, ldr_byp_data_q;
  klr_pkg::sub_ent_t sub_rd_q, sub_byp_data_q;
  klr_pkg::rel_ent_t rel_rd_q, rel_byp_data_q;
  logic              ldr_byp_q, sub_byp_q, rel_byp_q;

  // clearing pass after reset sweeps every entry to invalid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == klr_pkg::SUB_AW'(klr_pkg::SUB_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_comb begin
    wr = wr_i;
    if (clr_busy_q) begin
      wr.ldr_we   = 1'b1;
      wr.ldr_addr = clr_addr_q[klr_pkg::KEY_W-1:0];
      wr.ldr_data = '0;
      wr.sub_we   = 1'b1;
      wr.sub_addr = clr_addr_q;
      wr.sub_data = '0;
      wr.rel_we   = 1'b1;
      wr.rel_addr = clr_addr_q[klr_pkg::KEY_W-1:0];
      wr.rel_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.ldr_we) begin
      ldr_mem[wr.ldr_addr] <= wr.ldr_data;
    end
    if (rd_i.en) begin
      ldr_rd_q <= ldr_mem[rd_i.key];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.sub_we) begin
      sub_mem[wr.sub_addr] <= wr.sub_data;
    end
    if (rd_i.en) begin
      sub_rd_q <= sub_mem[rd_i.sub_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr.rel_we) begin
      rel_mem[wr.rel_addr] <= wr.rel_data;
    end
    if (rd_i.en) begin
      rel_rd_q <= rel_mem[rd_i.key];
    end
  end

  // a write to the entry read in the same cycle overrides the old read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ldr_byp_q <= 1'b0;
      sub_byp_q <= 1'b0;
      rel_byp_q <= 1'b0;
    end else if (rd_i.en) begin
      ldr_byp_q <= wr.ldr_we && (wr.ldr_addr == rd_i.key);
      sub_byp_q <= wr.sub_we && (wr.sub_addr == rd_i.sub_addr);
      rel_byp_q <= wr.rel_we && (wr.rel_addr == rd_i.key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      ldr_byp_data_q <= wr.ldr_data;
      sub_byp_data_q <= wr.sub_data;
      rel_byp_data_q <= wr.rel_data;
    end
  end

  assign rd_o.ldr   = ldr_byp_q ? ldr_byp_data_q : ldr_rd_q;
  assign rd_o.sub   = sub_byp_q ? sub_byp_data_q : sub_rd_q;
  assign rd_o.rel   = rel_byp_q ? rel_byp_data_q : rel_rd_q;
  assign clr_busy_o = clr_busy_q;

endmodule

FILE: rtl/core/klr_ctrl.sv
// input stage, page state and table update logic of the key layer remapper
module klr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  klr_pkg::in_item_t  in_item_i,
  input  logic               clr_busy_i,
  output klr_pkg::rd_req_t   rd_o,
  input  klr_pkg::rd_data_t  rd_data_i,
  output klr_pkg::wr_req_t   wr_o,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output klr_pkg::job_t      job_o
);

  logic                        s1_valid_q;
  klr_pkg::in_item_t           s1_q;
  logic                        page_active_q, page_active_d;
  logic [klr_pkg::KEY_W-1:0]   leader_code_q, leader_code_d;
  logic [klr_pkg::PAGE_W-1:0]  page_slot_q, page_slot_d;
  logic                        root_held_q, root_held_d;
  logic                        pedal_seen_q, pedal_seen_d;

  logic                        has_job, open_page, s1_fire, in_fire;
  logic                        ldr_we, sub_we, rel_we;
  klr_pkg::rel_ent_t           rel_wd;
  klr_pkg::job_t               job;
  logic [klr_pkg::PAGE_W-1:0]  slot_fwd;

  always_comb begin
    logic                      code_ok;
    logic [klr_pkg::KEY_W-1:0] key;
    code_ok       = s1_q.event_code < 16'(klr_pkg::KEY_CODES);
    key           = s1_q.event_code[klr_pkg::KEY_W-1:0];
    has_job       = 1'b0;
    open_page     = 1'b0;
    ldr_we        = 1'b0;
    sub_we        = 1'b0;
    rel_we        = 1'b0;
    rel_wd        = '0;
    job.shifted   = 1'b0;
    job.ev_type   = s1_q.event_type;
    job.ev_code   = s1_q.event_code;
    job.ev_value  = s1_q.event_value;
    page_active_d = page_active_q;
    leader_code_d = leader_code_q;
    page_slot_d   = page_slot_q;
    root_held_d   = root_held_q;
    pedal_seen_d  = pedal_seen_q;
    unique case (s1_q.action)
      klr_pkg::ACT_LEADER: ldr_we = 1'b1;
      klr_pkg::ACT_SUBST:  sub_we = 1'b1;
      klr_pkg::ACT_EVENT: begin
        if (s1_q.event_type == klr_pkg::EV_KEY) begin
          if (s1_q.event_value == 32'sd1) begin
            if (!page_active_q) begin
              if (code_ok && rd_data_i.ldr.valid) begin
                open_page     = 1'b1;
                page_active_d = 1'b1;
                leader_code_d = key;
                page_slot_d   = rd_data_i.ldr.page;
                root_held_d   = 1'b1;
                pedal_seen_d  = 1'b0;
              end else begin
                has_job = 1'b1;
              end
            end else begin
              has_job = 1'b1;
              if (code_ok && rd_data_i.sub.valid) begin
                job.ev_code = 16'(rd_data_i.sub.code);
                job.shifted = rd_data_i.sub.shift;
                rel_we      = 1'b1;
                rel_wd      = '{valid: 1'b1, code: rd_data_i.sub.code};
              end
              if (!root_held_q) begin
                page_active_d = 1'b0;
              end else begin
                pedal_seen_d = 1'b1;
              end
            end
          end else if (s1_q.event_value == 32'sd0) begin
            if (page_active_q && (s1_q.event_code == 16'(leader_code_q))) begin
              root_held_d = 1'b0;
              if (pedal_seen_q) begin
                page_active_d = 1'b0;
              end
            end else begin
              has_job = 1'b1;
              if (code_ok && rd_data_i.rel.valid) begin
                job.ev_code = 16'(rd_data_i.rel.code);
                rel_we      = 1'b1;
              end
            end
          end
        end else if (!(s1_q.event_type == klr_pkg::EV_MSC &&
                       s1_q.event_code == klr_pkg::MSC_CODE_SCAN)) begin
          has_job = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign s1_fire    = s1_valid_q && (!has_job || job_ready_i);
  assign in_ready_o = !clr_busy_i && (!s1_valid_q || s1_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  // the next item's page address sees a page opened by the item ahead of it
  assign slot_fwd = (s1_fire && open_page) ? rd_data_i.ldr.page : page_slot_q;

  assign rd_o.en       = in_fire;
  assign rd_o.key      = in_item_i.event_code[klr_pkg::KEY_W-1:0];
  assign rd_o.sub_addr = {slot_fwd, in_item_i.event_code[klr_pkg::KEY_W-1:0]};

  assign wr_o.ldr_we         = s1_fire && ldr_we;
  assign wr_o.ldr_addr       = s1_q.table_key;
  assign wr_o.ldr_data.valid = s1_q.table_valid;
  assign wr_o.ldr_data.page  = s1_q.table_valid ? s1_q.table_page : '0;
  assign wr_o.sub_we         = s1_fire && sub_we;
  assign wr_o.sub_addr       = {s1_q.table_page, s1_q.table_key};
  assign wr_o.sub_data.valid = s1_q.table_valid;
  assign wr_o.sub_data.shift = s1_q.table_valid && s1_q.table_shift;
  assign wr_o.sub_data.code  = s1_q.table_valid ? s1_q.table_code : '0;
  assign wr_o.rel_we         = s1_fire && rel_we;
  assign wr_o.rel_addr       = s1_q.event_code[klr_pkg::KEY_W-1:0];
  assign wr_o.rel_data       = rel_wd;

  assign job_valid_o = s1_valid_q && has_job;
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      page_active_q <= 1'b0;
      leader_code_q <= '0;
      page_slot_q   <= '0;
      root_held_q   <= 1'b0;
      pedal_seen_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        page_active_q <= page_active_d;
        leader_code_q <= leader_code_d;
        page_slot_q   <= page_slot_d;
        root_held_q   <= root_held_d;
        pedal_seen_q  <= pedal_seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_item_i;
    end
  end

endmodule

FILE: rtl/core/klr_emit.sv
// output sequencer that expands a job into one event or a shift-wrapped group
module klr_emit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  klr_pkg::job_t      job_i,
  input  logic [9:0]         shift_code_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output klr_pkg::out_item_t out_item_o
);

  typedef enum logic [4:0] {
    ST_FIRST    = 5'b00001,
    ST_SYN_A    = 5'b00010,
    ST_KEY      = 5'b00100,
    ST_SYN_B    = 5'b01000,
    ST_SHIFT_UP = 5'b10000
  } step_e;

  logic          busy_q;
  klr_pkg::job_t job_q;
  step_e         step_q, step_d;
  logic          out_fire, done;

  always_comb begin
    out_item_o.out_type  = klr_pkg::EV_KEY;
    out_item_o.out_code  = 16'(shift_code_i);
    out_item_o.out_value = 32'sd1;
    out_item_o.last      = 1'b0;
    step_d               = ST_FIRST;
    unique case (step_q)
      ST_FIRST: begin
        step_d = ST_SYN_A;
        if (!job_q.shifted) begin
          out_item_o.out_type  = job_q.ev_type;
          out_item_o.out_code  = job_q.ev_code;
          out_item_o.out_value = job_q.ev_value;
          out_item_o.last      = 1'b1;
        end
      end
      ST_SYN_A: begin
        step_d               = ST_KEY;
        out_item_o.out_type  = klr_pkg::EV_SYN;
        out_item_o.out_code  = klr_pkg::SYN_CODE_REPORT;
        out_item_o.out_value = 32'sd0;
      end
      ST_KEY: begin
        step_d              = ST_SYN_B;
        out_item_o.out_code = job_q.ev_code;
      end
      ST_SYN_B: begin
        step_d               = ST_SHIFT_UP;
        out_item_o.out_type  = klr_pkg::EV_SYN;
        out_item_o.out_code  = klr_pkg::SYN_CODE_REPORT;
        out_item_o.out_value = 32'sd0;
      end
      ST_SHIFT_UP: begin
        out_item_o.out_value = 32'sd0;
        out_item_o.last      = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = busy_q;
  assign out_fire    = busy_q && out_ready_i;
  assign done        = out_fire && out_item_o.last;
  assign job_ready_o = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= ST_FIRST;
    end else if (job_valid_i && job_ready_o) begin
      busy_q <= 1'b1;
      step_q <= ST_FIRST;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (out_fire) begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
  end

endmodule

FILE: rtl/core/key_layer_remapper.sv
// top level of the key layer remapper: shift code register, control, tables, sequencer
// path: the decode stage registers an input, then the output sequencer register holds its
//   job when its first result is offered; table writes and swallowed events give no result
// throughput: one input per cycle while each gives at most one result and out_ready_i stays
//   high; a shifted substitution holds the single output channel for 5 transfers
// reset: a clearing pass invalidates all table entries, in_ready_o low meanwhile
module key_layer_remapper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  klr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output klr_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [9:0]         cfg_wdata_i
);

  // shift key code injected around shifted substitutions
  logic [9:0]        shift_key_code_q;

  // read request, write-back and read data between control and tables
  klr_pkg::rd_req_t  rd_req;
  klr_pkg::wr_req_t  wr_req;
  klr_pkg::rd_data_t rd_data;
  logic              clr_busy;

  // one job per result-producing input, handed to the output sequencer
  logic              job_valid, job_ready;
  klr_pkg::job_t     job;

  // shift code writes are taken at any time, the clearing pass included
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_key_code_q <= klr_pkg::SHIFT_KEY_DEFAULT;
    end else if (cfg_we_i) begin
      shift_key_code_q <= cfg_wdata_i;
    end
  end

  // decode stage: reads the three tables at input transfer, decides in the cycle after it,
  // writes back and updates the page state when the decision moves on
  klr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .clr_busy_i  (clr_busy),
    .rd_o        (rd_req),
    .rd_data_i   (rd_data),
    .wr_o        (wr_req),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // memories with registered read, write bypass and the post-reset sweep
  klr_tables u_tables (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_i       (rd_req),
    .wr_i       (wr_req),
    .rd_o       (rd_data),
    .clr_busy_o (clr_busy)
  );

  // output sequencer: takes a job when idle or on the final transfer of the current one
  klr_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_ready_o  (job_ready),
    .job_i        (job),
    .shift_code_i (shift_key_code_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

FILE: rtl/core/klr_checker.sv
// port-level checks of the key layer remapper and their bind
`include "key_layer_remapper_defines.svh"

module klr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input klr_pkg::out_item_t out_item_o
);

  logic out_xfer, inner_xfer, inner_sync, inner_key, sync_clean, press_value;

  assign out_xfer    = out_valid_o && out_ready_i;
  // transfers inside a shift-wrapped group
  assign inner_xfer  = out_xfer && !out_item_o.last;
  assign inner_sync  = inner_xfer && (out_item_o.out_type == klr_pkg::EV_SYN);
  assign inner_key   = inner_xfer && (out_item_o.out_type == klr_pkg::EV_KEY);
  assign sync_clean  = (out_item_o.out_code == klr_pkg::SYN_CODE_REPORT) &&
                       (out_item_o.out_value == 32'sd0);
  assign press_value = out_item_o.out_value == 32'sd1;

  `KLR_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o))
  `KLR_ASSERT_NEXT(a_group_continues, inner_xfer, out_valid_o)
  `KLR_ASSERT_IMP(a_inner_sync, inner_sync, sync_clean)
  `KLR_ASSERT_IMP(a_inner_key_press, inner_key, press_value)

endmodule

bind key_layer_remapper klr_checker u_klr_checker (.*);
